// File: hdl/udtfmt_pkg.sv
// Package for the UDT flow metrics tracker.
// It holds the request and result structs, the kind codes and the status bit positions.
// It has no dependencies.
package udtfmt_pkg;

    localparam logic [2:0] KIND_DATA       = 3'd0;
    localparam logic [2:0] KIND_ACK        = 3'd1;
    localparam logic [2:0] KIND_NAK        = 3'd2;
    localparam logic [2:0] KIND_CONGESTION = 3'd3;
    localparam logic [2:0] KIND_DROP_REQ   = 3'd4;
    localparam logic [2:0] KIND_OTHER      = 3'd5;
    localparam logic [2:0] KIND_START      = 3'd6;

    localparam int ST_WINDOW_SHUT     = 0;
    localparam int ST_CONGESTED       = 1;
    localparam int ST_FIRST_DROP_ZERO = 2;
    localparam int ST_DROPS           = 3;
    localparam int ST_RETRANS         = 4;

    localparam int NAK_RANGE_BIT = 31;

    localparam logic [2:0] ACK_WORDS_ACK    = 3'd1;
    localparam logic [2:0] ACK_WORDS_RTT    = 3'd2;
    localparam logic [2:0] ACK_WORDS_WINDOW = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] seq_field;
        logic [1:0]  msg_class;
        logic [31:0] stamp_field;
        logic [63:0] now_time;
        logic [2:0]  ack_words;
        logic [31:0] ack_seq;
        logic [31:0] rtt_value;
        logic [31:0] window_size;
        logic [31:0] nak_word;
        logic        nak_first;
        logic        drop_first_zero;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  status;
        logic [31:0] last_seq;
        logic [31:0] last_stamp;
        logic [63:0] last_arrival;
        logic [31:0] drop_count;
        logic [31:0] retrans_count;
        logic [31:0] nacked_count;
        logic [31:0] gap_now;
        logic [31:0] class_count;
        logic [31:0] ack_seq_kept;
        logic [31:0] rtt_kept;
        logic [31:0] window_kept;
    } t_out_item;

endpackage

// File: hdl/udt_flow_metrics_tracker.sv
// Top level of the UDT flow metrics tracker: request register, handshake and result valid.
// It depends on udtfmt_pkg and udtfmt_core.
//
// Usage:
//   Requests enter on i_in_valid / o_in_ready with payload i_in_data, one packet event
//   or one NAK loss-list word per request. Each request yields exactly one result on
//   o_out_valid / i_out_ready with payload o_out_data, carrying the flow metrics after
//   that request has been applied.
//   The request is captured in an input register, and from there the update logic
//   applies it to the flow state and loads the result register.
//   Throughput is one request per cycle while the receiver takes results; the update
//   of the flow state is what sets it, so a request may follow in every cycle.
//   When the receiver stalls, the result register holds and the input register keeps
//   one more request, so o_in_ready drops only after both are full.
//   A synchronous reset on i_rst_n clears all counters, stored values and flags to zero
//   and empties both registers; the block accepts requests in the first cycle after it.
module udt_flow_metrics_tracker
    import udtfmt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic     r_in_valid;
    t_in_item r_in_data;
    logic     r_out_valid;
    logic     advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    udtfmt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_data),
        .o_result (o_out_data)
    );

    assign o_out_valid = r_out_valid;

    a_step_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("applied request produced no result");

    a_out_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result changed while the receiver stalled");

    a_in_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_data)))
        else $error("waiting request lost or changed");

endmodule

// File: hdl/udtfmt_core.sv
// Flow state and update logic for the UDT flow metrics tracker.
// One request is applied per step, and the result register loads the updated metrics.
// It depends on udtfmt_pkg.
module udtfmt_core
    import udtfmt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    logic [4:0]  r_status,  n_status;
    logic [31:0] r_seq,     n_seq;
    logic [31:0] r_stamp,   n_stamp;
    logic [63:0] r_arrival, n_arrival;
    logic [31:0] r_drops,   n_drops;
    logic [31:0] r_retrans, n_retrans;
    logic [31:0] r_nacked,  n_nacked;
    logic [31:0] r_class [4];
    logic [31:0] n_class [4];
    logic [31:0] r_ack,     n_ack;
    logic [31:0] r_rtt,     n_rtt;
    logic [31:0] r_window,  n_window;
    logic        r_range_open,  n_range_open;
    logic [30:0] r_range_begin, n_range_begin;
    t_out_item   r_result,  n_result;

    logic [31:0] seq_next;
    logic [31:0] seq_next2;
    logic [31:0] class_next;
    logic        range_live;
    logic [31:0] range_len;
    logic [31:0] gap;
    logic [31:0] cnt;

    assign seq_next   = r_seq + 32'd1;
    assign seq_next2  = r_seq + 32'd2;
    assign class_next = r_class[i_item.msg_class] + 32'd1;
    // The first word of a NAK closes any range left open by an earlier NAK.
    assign range_live = r_range_open && !i_item.nak_first;
    assign range_len  = i_item.nak_word - {1'b0, r_range_begin} + 32'd1;

    always_comb begin
        n_status      = r_status;
        n_seq         = r_seq;
        n_stamp       = r_stamp;
        n_arrival     = r_arrival;
        n_drops       = r_drops;
        n_retrans     = r_retrans;
        n_nacked      = r_nacked;
        n_class       = r_class;
        n_ack         = r_ack;
        n_rtt         = r_rtt;
        n_window      = r_window;
        n_range_open  = r_range_open;
        n_range_begin = r_range_begin;
        gap           = '0;
        cnt           = '0;
        case (i_item.kind)
            KIND_DATA: begin
                n_class[i_item.msg_class] = class_next;
                cnt = class_next;
                if (r_seq == '0) begin
                    n_seq     = i_item.seq_field;
                    n_stamp   = i_item.stamp_field;
                    n_arrival = i_item.now_time;
                end else if (i_item.seq_field > seq_next2) begin
                    // A forward jump moves the sequence but keeps the old stamp.
                    // Near the wrap this is checked before the in-order case.
                    gap                = i_item.seq_field - seq_next;
                    n_drops            = r_drops + gap;
                    n_status[ST_DROPS] = 1'b1;
                    n_seq              = i_item.seq_field;
                end else if (i_item.seq_field != seq_next) begin
                    n_retrans            = r_retrans + 32'd1;
                    n_status[ST_RETRANS] = 1'b1;
                end else begin
                    n_seq     = i_item.seq_field;
                    n_stamp   = i_item.stamp_field;
                    n_arrival = i_item.now_time;
                end
            end
            KIND_ACK: begin
                if (i_item.ack_words >= ACK_WORDS_ACK) begin
                    n_ack = i_item.ack_seq;
                end
                if (i_item.ack_words >= ACK_WORDS_RTT) begin
                    n_rtt = i_item.rtt_value;
                end
                if (i_item.ack_words >= ACK_WORDS_WINDOW) begin
                    n_window = i_item.window_size;
                    if (i_item.window_size == '0) begin
                        n_status[ST_WINDOW_SHUT] = 1'b1;
                    end
                end
            end
            KIND_NAK: begin
                if (i_item.nak_word[NAK_RANGE_BIT]) begin
                    n_range_begin = i_item.nak_word[30:0];
                    n_range_open  = 1'b1;
                end else begin
                    gap          = range_live ? range_len : 32'd1;
                    n_range_open = 1'b0;
                    n_nacked     = r_nacked + gap;
                end
            end
            KIND_CONGESTION: begin
                n_status[ST_CONGESTED] = 1'b1;
            end
            KIND_DROP_REQ: begin
                if (i_item.drop_first_zero) begin
                    n_status[ST_FIRST_DROP_ZERO] = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_result.status        = n_status;
        n_result.last_seq      = n_seq;
        n_result.last_stamp    = n_stamp;
        n_result.last_arrival  = n_arrival;
        n_result.drop_count    = n_drops;
        n_result.retrans_count = n_retrans;
        n_result.nacked_count  = n_nacked;
        n_result.gap_now       = gap;
        n_result.class_count   = cnt;
        n_result.ack_seq_kept  = n_ack;
        n_result.rtt_kept      = n_rtt;
        n_result.window_kept   = n_window;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status      <= '0;
            r_seq         <= '0;
            r_stamp       <= '0;
            r_arrival     <= '0;
            r_drops       <= '0;
            r_retrans     <= '0;
            r_nacked      <= '0;
            r_class       <= '{default: '0};
            r_ack         <= '0;
            r_rtt         <= '0;
            r_window      <= '0;
            r_range_open  <= 1'b0;
            r_range_begin <= '0;
        end else if (i_step) begin
            r_status      <= n_status;
            r_seq         <= n_seq;
            r_stamp       <= n_stamp;
            r_arrival     <= n_arrival;
            r_drops       <= n_drops;
            r_retrans     <= n_retrans;
            r_nacked      <= n_nacked;
            r_class       <= n_class;
            r_ack         <= n_ack;
            r_rtt         <= n_rtt;
            r_window      <= n_window;
            r_range_open  <= n_range_open;
            r_range_begin <= n_range_begin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

    // Status flags are sticky until reset.
    a_status_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((r_status & $past(r_status)) == $past(r_status)))
        else $error("status flag cleared without reset");

    a_hold_without_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !i_step) |=> ($stable(r_drops) && $stable(r_nacked) && $stable(r_seq)))
        else $error("flow state changed without a step");

    a_nak_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.kind == KIND_NAK && !i_item.nak_word[NAK_RANGE_BIT])
        |=> !r_range_open)
        else $error("range left open after a NAK range end");

    a_drop_gap_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.kind == KIND_DATA && n_drops != r_drops)
        |=> r_status[ST_DROPS])
        else $error("drop count moved without the drops flag");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Testbench for the UDT flow metrics tracker: directed and random packet events and NAK words.
// A clocked driver and monitor, a predictor of the flow state, and random stalls on both sides.
// It depends on udtfmt_pkg and udt_flow_metrics_tracker.
module testbench;
    import udtfmt_pkg::*;

    localparam logic [2:0] KIND_UNUSED      = 3'd7;
    localparam logic [2:0] ACK_WORDS_NONE   = 3'd0;
    localparam logic [2:0] ACK_WORDS_ALL    = 3'd7;
    localparam int         RANDOM_REQUESTS  = 1500;
    localparam int         SETTLE_CYCLES    = 10;

    typedef struct packed {
        logic     drain;
        t_in_item req;
    } t_pending;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    t_pending  pending[$];
    t_out_item metrics_due[$];
    int        error_count = 0;
    int        taken_total = 0;
    int        item_total = 0;
    int        send_gap = 0;
    int        stall_left = 0;
    bit        req_taken = 1'b0;
    bit        calm = 1'b0;

    // Flow state as the predictor sees it.
    logic [4:0]  flow_status = '0;
    logic [31:0] seq_seen = '0;
    logic [31:0] stamp_seen = '0;
    logic [63:0] arrival_seen = '0;
    logic [31:0] drops_total = '0;
    logic [31:0] retrans_total = '0;
    logic [31:0] nacked_total = '0;
    logic [31:0] class_total [4] = '{default: '0};
    logic [31:0] ack_held = '0;
    logic [31:0] rtt_held = '0;
    logic [31:0] window_held = '0;
    logic        nak_range_open = 1'b0;
    logic [30:0] nak_range_start = '0;

    udt_flow_metrics_tracker u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_out_item update_flow_metrics(input t_in_item req);
        t_out_item   res;
        logic [31:0] gap;
        logic [31:0] cnt;
        logic [31:0] seq_next;
        logic [31:0] seq_skip;
        gap = '0;
        cnt = '0;
        seq_next = seq_seen + 32'd1;
        seq_skip = seq_seen + 32'd2;
        case (req.kind)
            KIND_DATA: begin
                class_total[req.msg_class] = class_total[req.msg_class] + 32'd1;
                cnt = class_total[req.msg_class];
                if (seq_seen == '0) begin
                    seq_seen = req.seq_field;
                    stamp_seen = req.stamp_field;
                    arrival_seen = req.now_time;
                end else if (req.seq_field > seq_skip) begin
                    // A jump moves the sequence but keeps the old stamp and arrival.
                    gap = req.seq_field - seq_next;
                    drops_total = drops_total + gap;
                    flow_status[ST_DROPS] = 1'b1;
                    seq_seen = req.seq_field;
                end else if (req.seq_field != seq_next) begin
                    retrans_total = retrans_total + 32'd1;
                    flow_status[ST_RETRANS] = 1'b1;
                end else begin
                    seq_seen = req.seq_field;
                    stamp_seen = req.stamp_field;
                    arrival_seen = req.now_time;
                end
            end
            KIND_ACK: begin
                if (req.ack_words >= ACK_WORDS_ACK) ack_held = req.ack_seq;
                if (req.ack_words >= ACK_WORDS_RTT) rtt_held = req.rtt_value;
                if (req.ack_words >= ACK_WORDS_WINDOW) begin
                    window_held = req.window_size;
                    if (window_held == '0) flow_status[ST_WINDOW_SHUT] = 1'b1;
                end
            end
            KIND_NAK: begin
                if (req.nak_first) nak_range_open = 1'b0;
                if (req.nak_word[NAK_RANGE_BIT]) begin
                    nak_range_start = req.nak_word[30:0];
                    nak_range_open = 1'b1;
                end else begin
                    if (nak_range_open) begin
                        gap = req.nak_word - {1'b0, nak_range_start} + 32'd1;
                        nak_range_open = 1'b0;
                    end else begin
                        gap = 32'd1;
                    end
                    nacked_total = nacked_total + gap;
                end
            end
            KIND_CONGESTION: flow_status[ST_CONGESTED] = 1'b1;
            KIND_DROP_REQ: begin
                if (req.drop_first_zero) flow_status[ST_FIRST_DROP_ZERO] = 1'b1;
            end
            default: ;
        endcase
        res.status = flow_status;
        res.last_seq = seq_seen;
        res.last_stamp = stamp_seen;
        res.last_arrival = arrival_seen;
        res.drop_count = drops_total;
        res.retrans_count = retrans_total;
        res.nacked_count = nacked_total;
        res.gap_now = gap;
        res.class_count = cnt;
        res.ack_seq_kept = ack_held;
        res.rtt_kept = rtt_held;
        res.window_kept = window_held;
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    task automatic check_metrics(input t_out_item got, input t_out_item want);
        if (got.status !== want.status)
            flag_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.last_seq !== want.last_seq)
            flag_mismatch("last_seq", 64'(got.last_seq), 64'(want.last_seq));
        if (got.last_stamp !== want.last_stamp)
            flag_mismatch("last_stamp", 64'(got.last_stamp), 64'(want.last_stamp));
        if (got.last_arrival !== want.last_arrival)
            flag_mismatch("last_arrival", got.last_arrival, want.last_arrival);
        if (got.drop_count !== want.drop_count)
            flag_mismatch("drop_count", 64'(got.drop_count), 64'(want.drop_count));
        if (got.retrans_count !== want.retrans_count)
            flag_mismatch("retrans_count", 64'(got.retrans_count), 64'(want.retrans_count));
        if (got.nacked_count !== want.nacked_count)
            flag_mismatch("nacked_count", 64'(got.nacked_count), 64'(want.nacked_count));
        if (got.gap_now !== want.gap_now)
            flag_mismatch("gap_now", 64'(got.gap_now), 64'(want.gap_now));
        if (got.class_count !== want.class_count)
            flag_mismatch("class_count", 64'(got.class_count), 64'(want.class_count));
        if (got.ack_seq_kept !== want.ack_seq_kept)
            flag_mismatch("ack_seq_kept", 64'(got.ack_seq_kept), 64'(want.ack_seq_kept));
        if (got.rtt_kept !== want.rtt_kept)
            flag_mismatch("rtt_kept", 64'(got.rtt_kept), 64'(want.rtt_kept));
        if (got.window_kept !== want.window_kept)
            flag_mismatch("window_kept", 64'(got.window_kept), 64'(want.window_kept));
    endtask

    // Mostly short gaps, a few long ones, none at all during a calm stretch.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_in_item request_of(input logic [2:0] kind);
        t_in_item     req;
        logic [319:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
        req = noise[$bits(t_in_item)-1:0];
        req.kind = kind;
        return req;
    endfunction

    task automatic queue_request(input t_in_item req, input logic drain);
        pending.push_back('{drain: drain, req: req});
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || req_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending.size() != 0 &&
                         !(pending[0].drain && metrics_due.size() != 0)) begin
                i_in_valid <= 1'b1;
                i_in_data <= pending[0].req;
                void'(pending.pop_front());
                send_gap = idle_length();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            stall_left = idle_length();
        end
    end

    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0) calm = !calm;
        if (!i_rst_n) begin
            req_taken = 1'b0;
        end else begin
            req_taken = i_in_valid && o_in_ready;
            if (req_taken) begin
                metrics_due.push_back(update_flow_metrics(i_in_data));
                taken_total++;
            end
            if (o_out_valid && i_out_ready) begin
                if (metrics_due.size() == 0)
                    flag_mismatch("result with no request pending",
                                  64'(o_out_data.status), '0);
                else
                    check_metrics(o_out_data, metrics_due.pop_front());
            end
        end
    end

    initial begin
        t_in_item    req;
        int          n;
        int          r;
        int          j;
        int          words;
        logic [31:0] flow_seq;
        logic [30:0] nak_start;
        logic        pause_due;
        logic        mid_done;

        // Sequence tracking from an empty flow, through gaps and across the wrap.
        req = request_of(KIND_DATA); req.seq_field = 32'd0; req.msg_class = 2'd3;
        queue_request(req, 1'b0);
        req = request_of(KIND_DATA); req.seq_field = 32'd5; req.msg_class = 2'd2;
        req.stamp_field = '1; req.now_time = '1;
        queue_request(req, 1'b0);
        req = request_of(KIND_DATA); req.seq_field = 32'd6; req.msg_class = 2'd0;
        req.stamp_field = '0; req.now_time = '0;
        queue_request(req, 1'b0);
        req = request_of(KIND_DATA); req.seq_field = 32'd8; req.msg_class = 2'd1;
        queue_request(req, 1'b0);
        req = request_of(KIND_DATA); req.seq_field = 32'd20;
        queue_request(req, 1'b0);
        req = request_of(KIND_DATA); req.seq_field = 32'hFFFF_FFFF;
        queue_request(req, 1'b0);
        req = request_of(KIND_DATA); req.seq_field = 32'd0;
        queue_request(req, 1'b0);
        req = request_of(KIND_DATA); req.seq_field = 32'hFFFF_FFFF;
        queue_request(req, 1'b0);
        req = request_of(KIND_DATA); req.seq_field = 32'd1;
        queue_request(req, 1'b0);
        req = request_of(KIND_DATA); req.seq_field = 32'h8000_0000;
        queue_request(req, 1'b0);
        // Two below the wrap, the next number counts as a jump of zero.
        req = request_of(KIND_DATA); req.seq_field = 32'hFFFF_FFFE;
        queue_request(req, 1'b0);
        req = request_of(KIND_DATA); req.seq_field = 32'hFFFF_FFFF;
        queue_request(req, 1'b0);

        req = request_of(KIND_ACK); req.ack_words = ACK_WORDS_NONE;
        queue_request(req, 1'b0);
        req = request_of(KIND_ACK); req.ack_words = ACK_WORDS_RTT;
        queue_request(req, 1'b0);
        req = request_of(KIND_ACK); req.ack_words = ACK_WORDS_WINDOW; req.window_size = '0;
        queue_request(req, 1'b0);
        req = request_of(KIND_ACK); req.ack_words = ACK_WORDS_ALL;
        req.ack_seq = '1; req.rtt_value = '1; req.window_size = '1;
        queue_request(req, 1'b0);

        req = request_of(KIND_NAK); req.nak_first = 1'b1; req.nak_word = 32'd5;
        queue_request(req, 1'b0);
        req = request_of(KIND_NAK); req.nak_first = 1'b0; req.nak_word = 32'h8000_0010;
        queue_request(req, 1'b0);
        req = request_of(KIND_NAK); req.nak_first = 1'b0; req.nak_word = 32'h0000_0020;
        queue_request(req, 1'b0);
        // A range whose end lies below its start wraps the added count.
        req = request_of(KIND_NAK); req.nak_first = 1'b0; req.nak_word = 32'hFFFF_FFFF;
        queue_request(req, 1'b0);
        req = request_of(KIND_NAK); req.nak_first = 1'b0; req.nak_word = 32'h0000_0000;
        queue_request(req, 1'b0);
        // An open range is dropped when a new NAK begins.
        req = request_of(KIND_NAK); req.nak_first = 1'b0; req.nak_word = 32'h8000_0100;
        queue_request(req, 1'b0);
        req = request_of(KIND_NAK); req.nak_first = 1'b1; req.nak_word = 32'h0000_0200;
        queue_request(req, 1'b0);

        queue_request(request_of(KIND_CONGESTION), 1'b0);
        req = request_of(KIND_DROP_REQ); req.drop_first_zero = 1'b0;
        queue_request(req, 1'b0);
        req = request_of(KIND_DROP_REQ); req.drop_first_zero = 1'b1;
        queue_request(req, 1'b0);
        queue_request(request_of(KIND_OTHER), 1'b0);
        queue_request(request_of(KIND_START), 1'b0);
        queue_request(request_of(KIND_UNUSED), 1'b0);

        n = 0;
        flow_seq = 32'h8000_0000;
        pause_due = 1'b1;
        mid_done = 1'b0;
        while (n < RANDOM_REQUESTS) begin
            if (!mid_done && n >= RANDOM_REQUESTS / 2) begin
                pause_due = 1'b1;
                mid_done = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 55) begin
                req = request_of(KIND_DATA);
                r = $urandom_range(0, 99);
                if (r < 70) req.seq_field = flow_seq + 32'd1;
                else if (r < 80) req.seq_field = flow_seq + 32'($urandom_range(2, 60));
                else if (r < 92) req.seq_field = flow_seq - 32'($urandom_range(0, 20));
                else if (r < 97) req.seq_field = $urandom;
                else req.seq_field = 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
                if (r < 80 || r >= 92) flow_seq = req.seq_field;
                queue_request(req, pause_due);
                n++;
            end else if (r < 67) begin
                req = request_of(KIND_ACK);
                if ($urandom_range(0, 4) == 0) req.window_size = '0;
                queue_request(req, pause_due);
                n++;
            end else if (r < 82) begin
                // One NAK packet: singles and ranges, now and then a broken word.
                words = $urandom_range(1, 6);
                for (j = 0; j < words; j++) begin
                    req = request_of(KIND_NAK);
                    req.nak_first = (j == 0);
                    r = $urandom_range(0, 99);
                    if (r < 35) begin
                        req.nak_word = {1'b0, 31'($urandom)};
                    end else if (r < 85) begin
                        nak_start = 31'($urandom);
                        req.nak_word = {1'b1, nak_start};
                        queue_request(req, pause_due);
                        pause_due = 1'b0;
                        n++;
                        req = request_of(KIND_NAK);
                        req.nak_first = 1'b0;
                        req.nak_word = {1'b0, nak_start + 31'($urandom_range(0, 100))};
                    end else begin
                        req.nak_word = $urandom;
                    end
                    queue_request(req, pause_due);
                    pause_due = 1'b0;
                    n++;
                end
            end else if (r < 87) begin
                queue_request(request_of(KIND_CONGESTION), pause_due);
                n++;
            end else if (r < 92) begin
                queue_request(request_of(KIND_DROP_REQ), pause_due);
                n++;
            end else begin
                r = $urandom_range(0, 2);
                queue_request(request_of(r == 0 ? KIND_OTHER :
                                         r == 1 ? KIND_START : KIND_UNUSED), pause_due);
                n++;
            end
            if (n > 0) pause_due = 1'b0;
        end
        item_total = pending.size();

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (taken_total != item_total || metrics_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
